FILE: design/mpfg_pkg.sv
package mpfg_pkg;

  localparam int CHANNEL_COUNT = 32;
  localparam int USER_BASE     = 24;
  localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam int FRAME_W  = 32;
  localparam int DUTY_W   = 8;
  localparam int RES_W    = 4;
  localparam int DIV_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [RES_W-1:0] RES_RESET = 4'd8;
  localparam logic [RES_W-1:0] RES_MIN   = 4'd1;
  localparam logic [RES_W-1:0] RES_MAX   = 4'd8;

  localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;
  localparam logic [DUTY_W-1:0] ROUND_HALF = 8'd127;

  // Opcodes of the request channel.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_STATIC  = 3'd1;
  localparam logic [2:0] OP_PWM     = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_USER    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_APPLY
  } ctrl_state_e;

  typedef struct packed {
    logic latch_item;
    logic div_start;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: design/multichannel_pwm_frame_generator_core.sv
// Flow: a tick, set, PWM set, disable, user write or clear request is latched in ST_IDLE and
// committed to the output register in ST_APPLY; a duty readback passes ST_DIV_START and
// ST_DIV_WAIT in between, where the 16-step serial divider runs. ST_APPLY waits for a free output.
// A new request is taken only in ST_IDLE, once the previous one has been committed.
// Reset (rst_ni low, asynchronous): all channels static low, duties and phase zero,
// frame zero, resolution 8 bits, no result pending.
module multichannel_pwm_frame_generator_core import mpfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [5:0]         channel_i,
  input  logic               level_i,
  input  logic [7:0]         duty_in_i,
  input  logic [7:0]         user_value_i,
  input  logic [7:0]         user_select_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        frame_bits_o,
  output logic               frame_send_o,
  output logic [7:0]         duty_readback_o,
  output logic [7:0]         user_bits_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The controller walks each request through latch, optional divide and
  // commit; the datapath holds all channel state and the output register.
  // Since the output register is separate, a new request is taken while the
  // previous result still waits on the result channel.

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         cfg_we;
  logic [RES_W-1:0] res;

  // The only register is the resolution at byte addresses 0 to 3 (paddr[2] low). Writes to the
  // upper word are dropped and read back as zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {28'd0, res};

  mpfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpfg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (opcode_i),
    .channel_i       (channel_i),
    .level_i         (level_i),
    .duty_in_i       (duty_in_i),
    .user_value_i    (user_value_i),
    .user_select_i   (user_select_i),
    .cfg_we_i        (cfg_we),
    .cfg_res_i       (pwdata[RES_W-1:0]),
    .res_o           (res),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_bits_o    (frame_bits_o),
    .frame_send_o    (frame_send_o),
    .duty_readback_o (duty_readback_o),
    .user_bits_o     (user_bits_o)
  );

endmodule

FILE: design/mpfg_div.sv
module mpfg_div import mpfg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DUTY_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DIV_W-1:0]  quotient_o
);

  // Restoring divider, one quotient bit per cycle.
  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DUTY_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]     quot_q, quot_d;
  logic [DUTY_W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    trial  = {rem_q, quot_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = DUTY_W'(trial - {1'b0, divisor_i});
        quot_d = {quot_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DUTY_W-1:0];
        quot_d = {quot_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quot_q;

endmodule

FILE: design/mpfg_ctrl.sv
module mpfg_ctrl import mpfg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [2:0]   opcode_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          if (opcode_i == OP_READ) begin
            state_d = ST_DIV_START;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (status_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mpfg_datapath.sv
module mpfg_datapath import mpfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  input  logic [2:0]         opcode_i,
  input  logic [5:0]         channel_i,
  input  logic               level_i,
  input  logic [DUTY_W-1:0]  duty_in_i,
  input  logic [7:0]         user_value_i,
  input  logic [7:0]         user_select_i,
  input  logic               cfg_we_i,
  input  logic [RES_W-1:0]   cfg_res_i,
  output logic [RES_W-1:0]   res_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FRAME_W-1:0] frame_bits_o,
  output logic               frame_send_o,
  output logic [DUTY_W-1:0]  duty_readback_o,
  output logic [7:0]         user_bits_o
);

  // Latched request.
  logic [2:0]        op_q;
  logic [5:0]        ch_q;
  logic              level_q;
  logic [DUTY_W-1:0] duty_in_q;
  logic [7:0]        uval_q, usel_q;

  logic [RES_W-1:0] res_q;

  logic [CHANNEL_COUNT-1:0] static_q, static_d;
  logic [CHANNEL_COUNT-1:0] pwm_q, pwm_d;
  logic [DUTY_W-1:0]        duty_q [CHANNEL_COUNT];
  logic [DUTY_W-1:0]        duty_d [CHANNEL_COUNT];
  logic [DUTY_W-1:0]        phase_q, phase_d;
  logic [FRAME_W-1:0]       frame_q, frame_d;
  logic                     send_d;
  logic [DUTY_W-1:0]        rb_d;
  logic                     compose_en, clear_en;

  logic                     out_valid_q;
  logic [FRAME_W-1:0]       out_frame_q;
  logic                     out_send_q;
  logic [DUTY_W-1:0]        out_rb_q;

  logic [RES_W-1:0]    eff_bits;
  logic [DUTY_W-1:0]   max_step;
  logic                ch_valid;
  logic [CH_IDX_W-1:0] idx;
  logic [DUTY_W-1:0]   duty_sel;
  logic [DIV_W-1:0]    dividend;
  logic [DUTY_W-1:0]   divisor;
  logic                div_busy;
  logic [DIV_W-1:0]    quotient;
  logic [DIV_W-1:0]    scale_num;
  logic [DIV_W-1:0]    scale_quo;
  logic [DUTY_W-1:0]   scaled;
  logic [DUTY_W:0]     phase_inc;
  logic [FRAME_W-1:0]  composed;

  // Out-of-range resolutions clamp to the nearest legal value.
  always_comb begin
    if (res_q < RES_MIN) begin
      eff_bits = RES_MIN;
    end else if (res_q > RES_MAX) begin
      eff_bits = RES_MAX;
    end else begin
      eff_bits = res_q;
    end
  end

  assign max_step = DUTY_FULL >> (RES_MAX - eff_bits);
  assign ch_valid = {1'b0, ch_q} < 7'(CHANNEL_COUNT);
  assign idx      = ch_q[CH_IDX_W-1:0];
  assign duty_sel = ch_valid ? duty_q[idx] : '0;

  // The serial divider serves readback only, dividing by the max step with rounding.
  assign dividend = DIV_W'({duty_sel, 8'h00} - {8'h00, duty_sel})
                  + DIV_W'(max_step[DUTY_W-1:1]);
  assign divisor  = max_step;

  mpfg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Duty scaling divides by the constant 255 through a reciprocal: for a
  // numerator of at most 65534, n / 255 equals (n + (n >> 8) + 1) >> 8.
  assign scale_num = ({8'h00, duty_in_q} * {8'h00, max_step}) + DIV_W'(ROUND_HALF);
  assign scale_quo = (scale_num + (scale_num >> 8) + DIV_W'(1)) >> 8;
  assign scaled    = (scale_quo > DIV_W'(max_step)) ? max_step : scale_quo[DUTY_W-1:0];
  assign phase_inc = {1'b0, phase_q} + 1'b1;

  always_comb begin
    static_d   = static_q;
    pwm_d      = pwm_q;
    duty_d     = duty_q;
    phase_d    = phase_q;
    send_d     = 1'b0;
    rb_d       = '0;
    compose_en = 1'b0;
    clear_en   = 1'b0;
    case (op_q)
      OP_TICK: begin
        phase_d    = (phase_inc > {1'b0, max_step}) ? '0 : phase_inc[DUTY_W-1:0];
        compose_en = 1'b1;
        send_d     = 1'b1;
      end
      OP_STATIC: begin
        if (ch_valid) begin
          pwm_d[idx]    = 1'b0;
          static_d[idx] = level_q;
          duty_d[idx]   = level_q ? max_step : '0;
          compose_en    = 1'b1;
        end
      end
      OP_PWM: begin
        if (ch_valid) begin
          if (scaled == '0) begin
            pwm_d[idx]    = 1'b0;
            static_d[idx] = 1'b0;
            duty_d[idx]   = '0;
          end else if (scaled == max_step) begin
            pwm_d[idx]    = 1'b0;
            static_d[idx] = 1'b1;
            duty_d[idx]   = max_step;
          end else begin
            pwm_d[idx]    = 1'b1;
            static_d[idx] = 1'b0;
            duty_d[idx]   = scaled;
          end
        end
      end
      OP_DISABLE: begin
        if (ch_valid) begin
          pwm_d[idx]    = 1'b0;
          static_d[idx] = 1'b0;
          duty_d[idx]   = '0;
        end
      end
      OP_USER: begin
        for (int i = 0; i < 8; i++) begin
          if ((USER_BASE + i < CHANNEL_COUNT) && usel_q[i]) begin
            pwm_d[USER_BASE+i]    = 1'b0;
            static_d[USER_BASE+i] = uval_q[i];
            duty_d[USER_BASE+i]   = uval_q[i] ? max_step : '0;
          end
        end
      end
      OP_READ: begin
        if (ch_valid) begin
          if (!pwm_q[idx]) begin
            rb_d = static_q[idx] ? DUTY_FULL : '0;
          end else if (quotient > DIV_W'(DUTY_FULL)) begin
            rb_d = DUTY_FULL;
          end else begin
            rb_d = quotient[DUTY_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        static_d = '0;
        pwm_d    = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          duty_d[i] = '0;
        end
        phase_d  = '0;
        clear_en = 1'b1;
        send_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A PWM channel is high while its duty is above the phase.
  always_comb begin
    composed = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      composed[i] = pwm_d[i] ? (duty_d[i] > phase_d) : static_d[i];
    end
    if (compose_en) begin
      frame_d = composed;
    end else if (clear_en) begin
      frame_d = '0;
    end else begin
      frame_d = frame_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q      <= opcode_i;
      ch_q      <= channel_i;
      level_q   <= level_i;
      duty_in_q <= duty_in_i;
      uval_q    <= user_value_i;
      usel_q    <= user_select_i;
    end
    if (cmd_i.apply) begin
      out_frame_q <= frame_d;
      out_send_q  <= send_d;
      out_rb_q    <= rb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= RES_RESET;
      static_q    <= '0;
      pwm_q       <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        duty_q[i] <= '0;
      end
      phase_q     <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        res_q <= cfg_res_i;
      end
      if (cmd_i.apply) begin
        static_q    <= static_d;
        pwm_q       <= pwm_d;
        duty_q      <= duty_d;
        phase_q     <= phase_d;
        frame_q     <= frame_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign res_o           = res_q;
  assign out_valid_o     = out_valid_q;
  assign frame_bits_o    = out_frame_q;
  assign frame_send_o    = out_send_q;
  assign duty_readback_o = out_rb_q;
  assign user_bits_o     = out_frame_q[USER_BASE +: 8];

endmodule
